// ----- src/prcr_pkg.sv -----
// Shared types and constants of the sound-chip register clock rescaler.
// No dependencies; imported by the controller, the datapath and the top level.
package prcr_pkg;

	localparam int IDX_W   = 4;
	localparam int BYTE_W  = 8;
	localparam int CLK_W   = 16;
	localparam int PROD_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W   = $clog2(DIV_STEPS);

	localparam logic [CLK_W-1:0] TARGET_RESET = 16'd2500;
	localparam logic [CLK_W-1:0] SOURCE_RESET = 16'd2000;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd1;

	localparam logic [IDX_W-1:0] REG_NOISE  = 4'd6;
	localparam logic [IDX_W-1:0] REG_MIXER  = 4'd7;
	localparam logic [IDX_W-1:0] REG_ENV_LO = 4'd11;
	localparam logic [IDX_W-1:0] REG_ENV_HI = 4'd12;
	localparam logic [IDX_W-1:0] REG_SHAPE  = 4'd13;

	localparam logic [BYTE_W-1:0] MASK_MIXER = 8'h3F;
	localparam logic [BYTE_W-1:0] MASK_LEVEL = 8'h1F;
	localparam logic [BYTE_W-1:0] MASK_SHAPE = 8'h0F;
	localparam logic [BYTE_W-1:0] NOISE_MAX  = 8'd31;
	localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'hFF;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_TONE,
		OP_NOISE,
		OP_MASK,
		OP_ENV,
		OP_DROP
	} op_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_FIRST,
		EMIT_LAST
	} emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_WR_FIRST,
		ST_WR_LAST
	} state_t;

	typedef struct packed {
		logic  load;
		logic  mul;
		logic  div_step;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		op_t  in_op;
		op_t  cur_op;
		logic div_last;
		logic out_free;
	} sts_t;

	function automatic op_t decode_op(input logic [IDX_W-1:0] idx);
		op_t op;
		case (idx) inside
			4'd0, 4'd2, 4'd4, 4'd11: op = OP_HOLD;
			4'd1, 4'd3, 4'd5:        op = OP_TONE;
			4'd6:                    op = OP_NOISE;
			4'd7, [4'd8:4'd10], 4'd13: op = OP_MASK;
			4'd12:                   op = OP_ENV;
			default:                 op = OP_DROP;
		endcase
		return op;
	endfunction

endpackage

// ----- src/prcr_ctrl.sv -----
// Sequencing state machine of the clock rescaler.
// Depends on prcr_pkg; drives the datapath through cmd_t, reads sts_t back.
module prcr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  prcr_pkg::sts_t  sts,
	output prcr_pkg::cmd_t  cmd
);
	import prcr_pkg::*;

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (sts.in_op)
						OP_MASK:                   state_next = ST_WR_LAST;
						OP_TONE, OP_NOISE, OP_ENV: state_next = ST_MUL;
						default:                   state_next = ST_IDLE;
					endcase
				end
			end
			ST_MUL: state_next = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) begin
					if (sts.cur_op == OP_TONE || sts.cur_op == OP_ENV) begin
						state_next = ST_WR_FIRST;
					end else begin
						state_next = ST_WR_LAST;
					end
				end
			end
			ST_WR_FIRST: begin
				if (sts.out_free) begin
					state_next = ST_WR_LAST;
				end
			end
			ST_WR_LAST: begin
				if (sts.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.mul      = 1'b0;
		cmd.div_step = 1'b0;
		cmd.emit     = EMIT_NONE;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_MUL:      cmd.mul = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_WR_FIRST: cmd.emit = EMIT_FIRST;
			ST_WR_LAST:  cmd.emit = EMIT_LAST;
			default: ;
		endcase
	end

endmodule

// ----- src/prcr_datapath.sv -----
// Datapath of the clock rescaler: config registers, held low byte, multiplier,
// bit-serial restoring divider and the output word register. Depends on prcr_pkg.
module prcr_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [prcr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [prcr_pkg::CLK_W-1:0]        cfg_data,
	input  logic [prcr_pkg::IDX_W-1:0]        in_idx,
	input  logic [prcr_pkg::BYTE_W-1:0]       in_val,
	input  prcr_pkg::cmd_t                    cmd,
	output prcr_pkg::sts_t                    sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [prcr_pkg::IDX_W-1:0]        out_reg,
	output logic [prcr_pkg::BYTE_W-1:0]       out_val,
	output logic                              out_last
);
	import prcr_pkg::*;

	logic [CLK_W-1:0]  target_q, source_q;
	logic [BYTE_W-1:0] held_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] val_q;
	op_t               op_q;
	logic [CLK_W-1:0]  x_q;
	logic [PROD_W-1:0] quo_q;
	logic [CLK_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_reg_q;
	logic [BYTE_W-1:0] out_val_q;
	logic              out_last_q;

	op_t               in_op;
	logic [CLK_W-1:0]  x_next;
	logic [PROD_W-1:0] prod;
	logic [CLK_W:0]    rem_sh;
	logic              fits;
	logic              out_free;
	logic              sat_env, sat_noise;
	logic [IDX_W-1:0]  e_reg;
	logic [BYTE_W-1:0] e_val;
	logic [BYTE_W-1:0] mask_val;

	assign in_op    = decode_op(in_idx);
	assign out_free = !out_valid_q || out_ready;
	assign prod     = PROD_W'(x_q) * PROD_W'(target_q);
	assign rem_sh   = {rem_q, quo_q[PROD_W-1]};
	assign fits     = rem_sh >= {1'b0, source_q};
	assign sat_env   = |quo_q[PROD_W-1:2*BYTE_W];
	assign sat_noise = |quo_q[PROD_W-1:5];

	assign sts.in_op    = in_op;
	assign sts.cur_op   = op_q;
	assign sts.div_last = cnt_q == CNT_W'(DIV_STEPS - 1);
	assign sts.out_free = out_free;

	// Build the period to be scaled from the arriving byte and the held low byte
	always_comb begin
		case (in_op)
			OP_TONE:  x_next = {4'b0, in_val[3:0], held_q};
			OP_NOISE: x_next = {11'b0, in_val[4:0]};
			OP_ENV:   x_next = {in_val, held_q};
			default:  x_next = '0;
		endcase
	end

	always_comb begin
		case (idx_q)
			REG_MIXER: mask_val = val_q & MASK_MIXER;
			REG_SHAPE: mask_val = val_q & MASK_SHAPE;
			default:   mask_val = val_q & MASK_LEVEL;
		endcase
	end

	always_comb begin
		e_reg = idx_q;
		e_val = '0;
		case (op_q)
			OP_TONE: begin
				if (cmd.emit == EMIT_FIRST) begin
					e_reg = IDX_W'(idx_q - 4'd1);
					e_val = quo_q[7:0];
				end else begin
					e_val = {4'b0, quo_q[11:8]};
				end
			end
			OP_ENV: begin
				if (cmd.emit == EMIT_FIRST) begin
					e_reg = REG_ENV_LO;
					e_val = sat_env ? BYTE_MAX : quo_q[7:0];
				end else begin
					e_reg = REG_ENV_HI;
					e_val = sat_env ? BYTE_MAX : quo_q[15:8];
				end
			end
			OP_NOISE: begin
				e_reg = REG_NOISE;
				e_val = sat_noise ? NOISE_MAX : {3'b0, quo_q[4:0]};
			end
			OP_MASK: e_val = mask_val;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			source_q <= SOURCE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_TARGET) begin
				target_q <= cfg_data;
			end else if (cfg_index == CFG_SOURCE) begin
				source_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			op_q   <= OP_DROP;
		end else if (cmd.load) begin
			op_q <= in_op;
			if (in_op == OP_HOLD) begin
				held_q <= in_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= in_idx;
			val_q <= in_val;
			x_q   <= x_next;
		end
	end

	// Restoring divide, one quotient bit a cycle; quotient shifts in behind the dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mul) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= CNT_W'(cnt_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			quo_q <= prod;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= fits ? CLK_W'(rem_sh - {1'b0, source_q}) : rem_sh[CLK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EMIT_NONE && out_free) begin
			out_reg_q  <= e_reg;
			out_val_q  <= e_val;
			out_last_q <= cmd.emit == EMIT_LAST;
		end
	end

	assign out_valid = out_valid_q;
	assign out_reg   = out_reg_q;
	assign out_val   = out_val_q;
	assign out_last  = out_last_q;

endmodule

// ----- src/psg_register_clock_rescaler_core.sv -----
// Sound-chip register clock rescaler, top level: controller plus datapath.
// Tone, noise and envelope bytes pass from acceptance through the multiply, the
// bit-serial 32-step divider and an output load to the first word; masked bytes go
// straight to the output load. A new byte is taken only once the last word of the
// previous one has been loaded into the output register. Reset
// (arst_n, async) clears the held low byte, empties the output and loads 2500 / 2000 kHz.
module psg_register_clock_rescaler_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration writes
	input  logic                           cfg_we,
	input  logic [prcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prcr_pkg::CLK_W-1:0]     cfg_data,
	// Input words
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,  // [3:0] reg_index, [11:4] reg_value
	// Output words
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,  // [3:0] chip_reg, [11:4] chip_value
	output logic                           m_tlast   // last_write
);
	import prcr_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [IDX_W-1:0]  out_reg;
	logic [BYTE_W-1:0] out_val;

	// Controller: accepts a word only when idle, then steps multiply, divide and writes as the byte needs
	prcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: holds the result word in its output register so the sink may stall
	prcr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_idx    (s_tdata[3:0]),
		.in_val    (s_tdata[11:4]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_reg   (out_reg),
		.out_val   (out_val),
		.out_last  (m_tlast)
	);

	// Pack the write and pad the top nibble with zeros
	assign m_tdata = {4'b0, out_val, out_reg};

endmodule

// ----- sim/tb_psg_register_clock_rescaler_core.sv -----
// Self-checking testbench for psg_register_clock_rescaler_core: register bytes in, chip writes out.
// Depends on src/prcr_pkg.sv and the RTL of the core; holds its own predictor of the conversion.
`timescale 1ns / 1ps

module tb_psg_register_clock_rescaler_core;

	import prcr_pkg::*;

	// Register numbers of the sound chip that the package does not name
	localparam logic [IDX_W-1:0] REG_TONE_A_LO = 4'd0;
	localparam logic [IDX_W-1:0] REG_TONE_A_HI = 4'd1;
	localparam logic [IDX_W-1:0] REG_TONE_B_LO = 4'd2;
	localparam logic [IDX_W-1:0] REG_TONE_B_HI = 4'd3;
	localparam logic [IDX_W-1:0] REG_TONE_C_LO = 4'd4;
	localparam logic [IDX_W-1:0] REG_TONE_C_HI = 4'd5;
	localparam logic [IDX_W-1:0] REG_LEVEL_A   = 4'd8;
	localparam logic [IDX_W-1:0] REG_LEVEL_B   = 4'd9;
	localparam logic [IDX_W-1:0] REG_LEVEL_C   = 4'd10;
	localparam logic [IDX_W-1:0] REG_PORT_A    = 4'd14;
	localparam logic [IDX_W-1:0] REG_PORT_B    = 4'd15;

	// Configuration indexes that the block has no register behind
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam int IDLE_PCT       = 15;
	localparam int SETTLE_CYCLES  = 40;   // a scaled byte occupies the core for its multiply, divide and writes
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BYTES    = 48;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [IDX_W-1:0]  chip_reg;
		logic [BYTE_W-1:0] chip_value;
		logic              last_write;
	} chip_write_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CLK_W-1:0]   cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [15:0]        s_tdata;   // [3:0] reg_index, [11:4] reg_value
	logic               m_tvalid;
	logic               m_tready;
	logic [15:0]        m_tdata;   // [3:0] chip_reg, [11:4] chip_value
	logic               m_tlast;   // last_write

	// Predictor state: its own copy of the clocks and of the held low byte
	logic [CLK_W-1:0]   target_khz = TARGET_RESET;
	logic [CLK_W-1:0]   source_khz = SOURCE_RESET;
	logic [BYTE_W-1:0]  held_lo    = '0;
	chip_write_t        pending_writes[$];

	bit steady_flow    = 1'b0;   // set for a stretch in which neither side idles
	int bytes_sent     = 0;
	int writes_checked = 0;
	int mismatches     = 0;
	int clock_settings = 1;
	int stall_cycles   = 0;

	psg_register_clock_rescaler_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// period * target / source, truncating; a zero source gives all ones
	function automatic logic [31:0] scale_period(input logic [15:0] period);
		logic [63:0] product;
		logic [63:0] quotient;
		if (source_khz == '0)
			return '1;
		product  = 64'(period) * 64'(target_khz);
		quotient = product / 64'(source_khz);
		if (quotient > 64'hFFFF_FFFF)
			quotient = 64'hFFFF_FFFF;
		return quotient[31:0];
	endfunction

	task automatic push_write(input logic [IDX_W-1:0] chip_reg, input logic [BYTE_W-1:0] value,
			input logic last);
		chip_write_t w;
		w.chip_reg   = chip_reg;
		w.chip_value = value;
		w.last_write = last;
		pending_writes.push_back(w);
	endtask

	// Work out the chip writes caused by one accepted register byte
	task automatic predict_chip_writes(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		logic [31:0] scaled;
		case (idx)
			REG_TONE_A_LO, REG_TONE_B_LO, REG_TONE_C_LO, REG_ENV_LO: begin
				held_lo = val;
			end
			REG_TONE_A_HI, REG_TONE_B_HI, REG_TONE_C_HI: begin
				// only bits 0..11 of the scaled period survive, so the high nibble wraps
				scaled = scale_period({4'b0, val[3:0], held_lo});
				push_write(idx - 4'd1, scaled[7:0], 1'b0);
				push_write(idx, {4'b0, scaled[11:8]}, 1'b1);
			end
			REG_NOISE: begin
				scaled = scale_period({11'b0, val[4:0]});
				push_write(REG_NOISE, (scaled > 32'(NOISE_MAX)) ? NOISE_MAX : scaled[7:0], 1'b1);
			end
			REG_MIXER: push_write(REG_MIXER, val & MASK_MIXER, 1'b1);
			REG_LEVEL_A, REG_LEVEL_B, REG_LEVEL_C: push_write(idx, val & MASK_LEVEL, 1'b1);
			REG_ENV_HI: begin
				scaled = scale_period({val, held_lo});
				if (scaled > 32'h0000_FFFF) begin
					push_write(REG_ENV_LO, BYTE_MAX, 1'b0);
					push_write(REG_ENV_HI, BYTE_MAX, 1'b1);
				end else begin
					push_write(REG_ENV_LO, scaled[7:0], 1'b0);
					push_write(REG_ENV_HI, scaled[15:8], 1'b1);
				end
			end
			REG_SHAPE: push_write(REG_SHAPE, val & MASK_SHAPE, 1'b1);
			default: ;   // port registers: drop
		endcase
	endtask

	// ---------------------------------------------------------------- drivers

	// Receiver: stall at random, except during the steady stretch
	always @(negedge clk) begin
		m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
	end

	// Offer one register byte, hold it until the core takes it, then predict
	task automatic send_reg_byte(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, val, idx};
		do @(posedge clk); while (!s_tready);
		predict_chip_writes(idx, val);
		if (idx != REG_PORT_A && idx != REG_PORT_B)
			bytes_sent++;
	endtask

	// Drop valid, wait for every expected word, then let a held or dropped byte finish too
	task automatic wait_writes_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one configuration register; only called with the core idle
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == CFG_TARGET)
			target_khz = data;
		else if (idx == CFG_SOURCE)
			source_khz = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_clocks(input logic [CLK_W-1:0] target, input logic [CLK_W-1:0] source);
		wait_writes_drained();
		cfg_write(CFG_TARGET, target);
		cfg_write(CFG_SOURCE, source);
		clock_settings++;
	endtask

	// ---------------------------------------------------------------- checker

	// Compare every accepted word with the oldest expectation
	always @(posedge clk) begin
		chip_write_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t unexpected word: reg %0d value %02h last %0b", $realtime,
						m_tdata[3:0], m_tdata[11:4], m_tlast);
			end else begin
				exp_w = pending_writes.pop_front();
				writes_checked++;
				if (m_tdata[3:0] !== exp_w.chip_reg || m_tdata[11:4] !== exp_w.chip_value ||
						m_tlast !== exp_w.last_write) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t mismatch: expected reg %0d value %02h last %0b,",
							$realtime, exp_w.chip_reg, exp_w.chip_value, exp_w.last_write,
							" got reg %0d value %02h last %0b",
							m_tdata[3:0], m_tdata[11:4], m_tlast);
				end
			end
		end
	end

	// Watchdog: end the run if neither side moves a word for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	// One frame in register order with random content; broken frames skip bytes, and port bytes are mostly skipped
	task automatic send_random_frame(input bit broken);
		for (int r = 0; r < 16; r++) begin
			if (broken && $urandom_range(9) == 0)
				continue;
			if (r >= int'(REG_PORT_A) && $urandom_range(3) != 0)
				continue;
			send_reg_byte(IDX_W'(r), BYTE_W'($urandom_range(255)));
		end
	endtask

	// Random bytes at random registers, out of any order
	task automatic send_noise_burst();
		int n;
		n = $urandom_range(6, 1);
		repeat (n) send_reg_byte(IDX_W'($urandom_range(15)), BYTE_W'($urandom_range(255)));
	endtask

	task automatic run_random_phase();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < PHASE_BYTES) begin
			if ($urandom_range(9) < 7)
				send_random_frame(1'b0);
			else if ($urandom_range(1) == 0)
				send_random_frame(1'b1);
			else
				send_noise_burst();
			// pause the sender now and then until the output has caught up
			if ($urandom_range(9) == 0)
				wait_writes_drained();
		end
	endtask

	// High byte straight after reset pairs with a low byte of zero
	task automatic test_reset_defaults();
		send_reg_byte(REG_TONE_A_HI, 8'h0F);
		send_reg_byte(REG_ENV_HI, 8'h01);
	endtask

	// Extremes of each field and each kind of register at the reset clocks
	task automatic test_directed_fields();
		send_reg_byte(REG_TONE_A_LO, 8'hFF);
		send_reg_byte(REG_TONE_A_HI, 8'hFF);   // high nibble wraps
		send_reg_byte(REG_TONE_B_LO, 8'h00);
		send_reg_byte(REG_TONE_B_HI, 8'h00);
		send_reg_byte(REG_TONE_C_LO, 8'h5A);
		send_reg_byte(REG_TONE_C_HI, 8'hF3);   // upper nibble ignored
		send_reg_byte(REG_NOISE, 8'h00);
		send_reg_byte(REG_NOISE, 8'hFF);       // saturates at 31
		send_reg_byte(REG_NOISE, 8'h0A);
		send_reg_byte(REG_MIXER, 8'hFF);
		send_reg_byte(REG_MIXER, 8'h00);
		send_reg_byte(REG_LEVEL_A, 8'hFF);
		send_reg_byte(REG_LEVEL_B, 8'hE0);
		send_reg_byte(REG_LEVEL_C, 8'h15);
		send_reg_byte(REG_ENV_LO, 8'hFF);
		send_reg_byte(REG_ENV_HI, 8'hFF);      // envelope overflow
		send_reg_byte(REG_ENV_LO, 8'h00);
		send_reg_byte(REG_ENV_HI, 8'h10);
		send_reg_byte(REG_SHAPE, 8'hFF);
		send_reg_byte(REG_SHAPE, 8'hF0);
		send_reg_byte(REG_PORT_A, 8'hFF);
		send_reg_byte(REG_PORT_B, 8'hAA);
	endtask

	// Clock ratios at the extremes, including a zero source clock
	task automatic test_clock_extremes();
		set_clocks(16'hFFFF, 16'd1);
		run_random_phase();
		set_clocks(16'd1, 16'hFFFF);
		run_random_phase();
		// neither side idles through this setting
		set_clocks(16'hFFFF, 16'hFFFF);
		steady_flow = 1'b1;
		run_random_phase();
		steady_flow = 1'b0;
		set_clocks(16'd1, 16'd1);
		run_random_phase();
		set_clocks(CLK_W'($urandom_range(65535, 1)), 16'd0);
		run_random_phase();
	endtask

	// Writes to unused indexes leave both clocks as they were
	task automatic test_spare_indexes();
		wait_writes_drained();
		cfg_write(CFG_SPARE_LO, CLK_W'($urandom_range(65535)));
		cfg_write(CFG_SPARE_HI, CLK_W'($urandom_range(65535)));
		set_clocks(CLK_W'($urandom_range(65535, 1)), CLK_W'($urandom_range(65535, 1)));
		cfg_write(CFG_SPARE_HI, 16'hFFFF);
		run_random_phase();
	endtask

	// Back to the usual ratio for a final random stretch
	task automatic test_usual_ratio();
		set_clocks(TARGET_RESET, SOURCE_RESET);
		run_random_phase();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_directed_fields();
		wait_writes_drained();   // sender holds off until the output has caught up
		test_clock_extremes();
		test_spare_indexes();
		test_usual_ratio();
		wait_writes_drained();

		$display("Sent %0d register bytes and checked %0d chip writes across %0d clock settings,",
			bytes_sent, writes_checked, clock_settings);
		$display("covering every register, both ratio extremes, a zero source clock and unused indexes.");
		if (mismatches == 0 && pending_writes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d writes never seen", mismatches, pending_writes.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
